[src/wfd_pkg.sv]
// Package for the word frequency dictionary: payload structs, FSM states,
// status codes and character constants. No dependencies.
`default_nettype none

package wfd_pkg;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned STAT_W  = 2;

  localparam logic [7:0]         CHAR_SPACE   = 8'd32;
  localparam logic [7:0]         CHAR_NEWLINE = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

  localparam logic [STAT_W-1:0] STAT_SEEN = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NEW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   entry_index;
    logic [COUNT_W-1:0] entry_count;
    logic [STAT_W-1:0]  word_status;
    logic               word_truncated;
  } out_t;

  typedef struct packed {
    logic chr_we;
    logic chr_re;
    logic meta_we;
    logic meta_re;
  } store_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_MCHK,
    ST_CHR,
    ST_COPY,
    ST_MWR,
    ST_RES
  } state_e;

endpackage

`default_nettype wire

[src/wfd_store.sv]
// Dictionary storage: character memory and length/count memory, both with
// registered reads. Depends on wfd_pkg.
`default_nettype none

module wfd_store import wfd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned WORD_CHARS  = 32,
  localparam int unsigned EW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned KW     = $clog2(WORD_CHARS),
  localparam int unsigned LW     = $clog2(WORD_CHARS + 1),
  localparam int unsigned META_W = LW + COUNT_W
) (
  input  wire  logic              clk_i,
  input  wire  store_ctl_t        ctl_i,
  input  wire  logic [EW+KW-1:0]  chr_addr_i,
  input  wire  logic [7:0]        chr_wdata_i,
  output       logic [7:0]        chr_rdata_o,
  input  wire  logic [EW-1:0]     meta_addr_i,
  input  wire  logic [META_W-1:0] meta_wdata_i,
  output       logic [META_W-1:0] meta_rdata_o
);

  logic [7:0]        chr_mem  [TABLE_DEPTH << KW];
  logic [META_W-1:0] meta_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.chr_we) begin
      chr_mem[chr_addr_i] <= chr_wdata_i;
    end
    if (ctl_i.chr_re) begin
      chr_rdata_o <= chr_mem[chr_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.meta_we) begin
      meta_mem[meta_addr_i] <= meta_wdata_i;
    end
    if (ctl_i.meta_re) begin
      meta_rdata_o <= meta_mem[meta_addr_i];
    end
  end

endmodule

`default_nettype wire

[src/word_frequency_dictionary_top.sv]
// Word frequency dictionary top level: byte intake, pending word, search and
// update sequencer, output register. Depends on wfd_pkg and wfd_store.
//
// Usage:
//   The input channel carries one text byte per transaction (in_data_i).
//   Space and newline end a word; runs of them produce no empty words.
//   A completed word yields one output transaction with its table index,
//   running count (saturating), status and truncation flag.
//   A byte that does not end a word is taken while the sequencer stays idle.
//   A word end walks the stored entries in order through the registered-read
//   memories: a length read (ST_META) and check (ST_MCHK) per entry, then a
//   character compare (ST_CHR) for an entry of equal length, left early on a
//   mismatch. A match leads to a count write (ST_MWR); reaching the end of
//   the table with no match leads to a copy of the word into the table
//   (ST_COPY, ST_MWR), or to no write when the table is full. Loading the
//   output register (ST_RES) ends it. The entry walk sets the throughput.
//   in_stall_o is high while a word end is in progress.
//   end_of_text flushes the pending word, then empties the table; the
//   stored bytes are not cleared, an empty table simply never reads them.
//   Reset empties the table and the pending word at once; no clearing pass.
//   When the receiver stalls, the finished transaction holds in the output
//   register; further bytes are still taken, and the next word end waits
//   only at its final step for the register to free up.
`default_nettype none

module word_frequency_dictionary_top import wfd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned WORD_CHARS  = 32
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output       logic in_stall_o,
  input  wire  in_t  in_data_i,
  output       logic out_valid_o,
  input  wire  logic out_stall_i,
  output       out_t out_data_o
);

  localparam int unsigned EW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned UW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW     = $clog2(WORD_CHARS);
  localparam int unsigned LW     = $clog2(WORD_CHARS + 1);
  localparam int unsigned META_W = LW + COUNT_W;

  state_e state_q, state_d;

  // Pending word, kept until its result is loaded.
  logic [7:0]    pend_q [WORD_CHARS];
  logic [LW-1:0] plen_q;
  logic          cut_q;
  logic [UW-1:0] used_q;
  logic          eot_q;

  // Walk pointers.
  logic [UW-1:0] e_q;
  logic [KW-1:0] k_q;

  // Result under construction.
  logic [EW-1:0]      res_idx_q;
  logic [COUNT_W-1:0] res_cnt_q;
  logic [STAT_W-1:0]  res_st_q;

  logic out_valid_q;
  out_t out_q;

  store_ctl_t        ctl;
  logic [EW+KW-1:0]  chr_addr;
  logic [7:0]        chr_rdata;
  logic [EW-1:0]     meta_addr;
  logic [META_W-1:0] meta_wdata, meta_rdata;

  logic               acc, is_delim, start, clear_now;
  logic               len_hit, chr_hit, last_k, e_end, full, out_free;
  logic [LW-1:0]      meta_len;
  logic [COUNT_W-1:0] meta_cnt;

  assign acc       = in_valid_i && (state_q == ST_IDLE);
  assign is_delim  = (in_data_i.text_byte == CHAR_SPACE) ||
                     (in_data_i.text_byte == CHAR_NEWLINE);
  // A word ends on a delimiter with something pending, or on end_of_text
  // carried by a word byte (which always leaves something pending).
  assign start     = is_delim ? (plen_q != '0) : in_data_i.end_of_text;
  assign clear_now = is_delim && (plen_q == '0) && in_data_i.end_of_text;

  assign meta_len = meta_rdata[META_W-1:COUNT_W];
  assign meta_cnt = meta_rdata[COUNT_W-1:0];
  assign len_hit  = meta_len == plen_q;
  assign chr_hit  = chr_rdata == pend_q[k_q];
  assign last_k   = (LW'(k_q) + LW'(1)) == plen_q;
  assign e_end    = e_q == used_q;
  assign full     = used_q == UW'(TABLE_DEPTH);
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (acc && start) state_d = ST_META;
      ST_META: begin
        if (e_end) state_d = full ? ST_RES : ST_COPY;
        else       state_d = ST_MCHK;
      end
      ST_MCHK: state_d = len_hit ? ST_CHR : ST_META;
      ST_CHR: begin
        if (!chr_hit)    state_d = ST_META;
        else if (last_k) state_d = ST_MWR;
      end
      ST_COPY: if (last_k) state_d = ST_MWR;
      ST_MWR:  state_d = ST_RES;
      ST_RES:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory controls and handshake outputs.
  always_comb begin
    ctl        = '0;
    chr_addr   = {e_q[EW-1:0], KW'(k_q + KW'(1))};
    meta_addr  = e_q[EW-1:0];
    meta_wdata = {plen_q, res_cnt_q};
    unique case (state_q)
      ST_META: ctl.meta_re = !e_end;
      ST_MCHK: begin
        ctl.chr_re = len_hit;
        chr_addr   = {e_q[EW-1:0], KW'(0)};
      end
      ST_CHR:  ctl.chr_re = chr_hit && !last_k;
      ST_COPY: begin
        ctl.chr_we = 1'b1;
        chr_addr   = {used_q[EW-1:0], k_q};
      end
      ST_MWR: begin
        ctl.meta_we = 1'b1;
        meta_addr   = res_idx_q;
      end
      default: ;
    endcase
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  wfd_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WORD_CHARS  (WORD_CHARS)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .chr_addr_i   (chr_addr),
    .chr_wdata_i  (pend_q[k_q]),
    .chr_rdata_o  (chr_rdata),
    .meta_addr_i  (meta_addr),
    .meta_wdata_i (meta_wdata),
    .meta_rdata_o (meta_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      plen_q      <= '0;
      cut_q       <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc) begin
        if (!is_delim) begin
          if (plen_q < LW'(WORD_CHARS)) plen_q <= plen_q + LW'(1);
          else                          cut_q  <= 1'b1;
        end
        if (clear_now) begin
          used_q <= '0;
        end
      end
      if (state_q == ST_MWR && res_st_q == STAT_NEW) begin
        used_q <= used_q + UW'(1);
      end
      if (state_q == ST_RES && out_free) begin
        out_valid_q <= 1'b1;
        plen_q      <= '0;
        cut_q       <= 1'b0;
        if (eot_q) used_q <= '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk_i) begin
    if (acc && !is_delim && plen_q < LW'(WORD_CHARS)) begin
      pend_q[plen_q[KW-1:0]] <= in_data_i.text_byte;
    end
    unique case (state_q)
      ST_IDLE: begin
        e_q   <= '0;
        eot_q <= in_data_i.end_of_text;
      end
      ST_META: begin
        k_q <= '0;
        if (e_end) begin
          res_idx_q <= full ? '0 : used_q[EW-1:0];
          res_cnt_q <= full ? '0 : COUNT_W'(1);
          res_st_q  <= full ? STAT_FULL : STAT_NEW;
        end
      end
      ST_MCHK: if (!len_hit) e_q <= e_q + UW'(1);
      ST_CHR: begin
        if (!chr_hit) begin
          e_q <= e_q + UW'(1);
          k_q <= '0;
        end else if (last_k) begin
          res_idx_q <= e_q[EW-1:0];
          res_cnt_q <= (meta_cnt == COUNT_MAX) ? COUNT_MAX : meta_cnt + COUNT_W'(1);
          res_st_q  <= STAT_SEEN;
        end else begin
          k_q <= k_q + KW'(1);
        end
      end
      ST_COPY: k_q <= k_q + KW'(1);
      ST_RES: begin
        if (out_free) begin
          out_q.entry_index    <= IDX_W'(res_idx_q);
          out_q.entry_count    <= res_cnt_q;
          out_q.word_status    <= res_st_q;
          out_q.word_truncated <= cut_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[tb/wfd_checker.sv]
`timescale 1ns / 1ps
// Checker for the word frequency dictionary: watches both channels, keeps its
// own copy of the word table and compares every output transaction. Needs wfd_pkg.
module wfd_checker import wfd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned WORD_CHARS  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   words_pending_o,
  output int   words_seen_o
);

  logic [7:0]         tbl_chars [TABLE_DEPTH][WORD_CHARS];
  int                 tbl_len   [TABLE_DEPTH];
  logic [COUNT_W-1:0] tbl_count [TABLE_DEPTH];
  int                 tbl_used;
  logic [7:0]         word_chars [WORD_CHARS];
  int                 word_len;
  logic               word_cut;
  out_t               word_results [$];

  initial begin
    fail_count_o = 0;
    words_seen_o = 0;
    tbl_used = 0;
    word_len = 0;
    word_cut = 1'b0;
  end

  assign words_pending_o = word_results.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Look up the pending word, bump or append it, and queue the outcome.
  function automatic void close_word();
    out_t r;
    bit   hit;
    hit = 0;
    r = '0;
    r.word_status = STAT_FULL;
    for (int e = 0; e < tbl_used && !hit; e++) begin
      if (tbl_len[e] == word_len) begin
        hit = 1;
        for (int k = 0; k < word_len; k++)
          if (tbl_chars[e][k] != word_chars[k]) hit = 0;
        if (hit) begin
          if (tbl_count[e] != COUNT_MAX) tbl_count[e]++;
          r.entry_index = IDX_W'(e);
          r.entry_count = tbl_count[e];
          r.word_status = STAT_SEEN;
        end
      end
    end
    if (!hit && tbl_used < TABLE_DEPTH) begin
      for (int k = 0; k < word_len; k++) tbl_chars[tbl_used][k] = word_chars[k];
      tbl_len[tbl_used] = word_len;
      tbl_count[tbl_used] = COUNT_W'(1);
      r.entry_index = IDX_W'(tbl_used);
      r.entry_count = COUNT_W'(1);
      r.word_status = STAT_NEW;
      tbl_used++;
    end
    r.word_truncated = word_cut;
    word_results.push_back(r);
    word_len = 0;
    word_cut = 1'b0;
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    bit   closed;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      closed = 0;
      if (in_data_i.text_byte == CHAR_SPACE || in_data_i.text_byte == CHAR_NEWLINE) begin
        if (word_len > 0) begin
          close_word();
          closed = 1;
        end
      end else if (word_len < WORD_CHARS) begin
        word_chars[word_len] = in_data_i.text_byte;
        word_len++;
      end else begin
        word_cut = 1'b1;
      end
      if (in_data_i.end_of_text) begin
        if (word_len > 0 && !closed) close_word();
        tbl_used = 0;
        word_len = 0;
        word_cut = 1'b0;
      end
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      words_seen_o++;
      if (word_results.size() == 0) begin
        report("unexpected transaction, index", out_data_i.entry_index, -1);
      end else begin
        want = word_results.pop_front();
        if (out_data_i.entry_index != want.entry_index)
          report("entry_index", out_data_i.entry_index, want.entry_index);
        if (out_data_i.entry_count != want.entry_count)
          report("entry_count", out_data_i.entry_count, want.entry_count);
        if (out_data_i.word_status != want.word_status)
          report("word_status", out_data_i.word_status, want.word_status);
        if (out_data_i.word_truncated != want.word_truncated)
          report("word_truncated", out_data_i.word_truncated, want.word_truncated);
      end
    end
  end

endmodule

[tb/tb_word_frequency_dictionary_top.sv]
`timescale 1ns / 1ps
// Testbench top for the word frequency dictionary: drives text bytes, applies
// output back-pressure and gives the verdict. Needs wfd_pkg and wfd_checker.
module tb_word_frequency_dictionary_top;
  import wfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  int fail_count;
  int words_pending;
  int words_seen;
  int bytes_sent;
  int idle_cycles;
  bit calm_phase;    // no idling on either side while set
  bit hold_output;   // long receiver hold-off while set

  word_frequency_dictionary_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  wfd_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .words_pending_o(words_pending),
    .words_seen_o(words_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    calm_phase = 1'b0;
    hold_output = 1'b0;
    bytes_sent = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: stall about one cycle in ten, never while calm, always during a hold.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= hold_output || (!calm_phase && $urandom_range(99) < 10);
    end
  end

  // Offer one transaction; idle first at random, then hold until accepted.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while (!calm_phase && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{text_byte: b, end_of_text: eot};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_word(input string w, input logic [7:0] sep);
    for (int k = 0; k < w.len(); k++) send_byte(w[k], 1'b0);
    send_byte(sep, 1'b0);
  endtask

  // Random word character: never a delimiter, sometimes a high byte.
  function automatic logic [7:0] word_char(input int alphabet);
    logic [7:0] c;
    if ($urandom_range(15) == 0) begin
      do c = 8'($urandom_range(255)); while (c == CHAR_SPACE || c == CHAR_NEWLINE);
    end else begin
      c = 8'd97 + 8'($urandom_range(alphabet - 1));
    end
    return c;
  endfunction

  // Drop valid first so the last byte is not taken again while draining.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (words_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed: repeats, delimiter runs, newline, overlong words sharing a prefix,
    // all-ones and zero bytes, end_of_text on a letter and on a delimiter.
    send_word("ab", CHAR_SPACE);
    send_byte(CHAR_NEWLINE, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_word("ab", CHAR_NEWLINE);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_byte(8'd120, 1'b1);
    send_byte(CHAR_SPACE, 1'b1);
    send_byte(CHAR_NEWLINE, 1'b1);
    for (int r = 0; r < 2; r++) begin
      for (int k = 0; k < 34 + r; k++) send_byte(8'd113, 1'b0);
      send_byte(CHAR_SPACE, 1'b0);
    end
    for (int k = 0; k < 32; k++) send_byte(8'd113, 1'b0);
    send_byte(CHAR_SPACE, 1'b1);
    wait_drained();

    // Fill the table past its depth so later new words report full.
    for (int w = 0; w < 66; w++) begin
      send_byte(8'd65 + w[5:0], 1'b0);
      send_byte(8'd48 + w[6], 1'b0);
      send_byte(CHAR_SPACE, 1'b0);
    end
    send_byte(8'd65, 1'b0);
    send_byte(8'd48, 1'b0);
    send_byte(CHAR_SPACE, 1'b1);
    wait_drained();

    // Pressure: stall the output while text keeps flowing.
    fork
      begin
        hold_output = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_output = 1'b0;
      end
      for (int w = 0; w < 12; w++) send_word("hey", CHAR_SPACE);
    join
    wait_drained();

    // Random: mostly short words from a small alphabet so repeats occur.
    n = 0;
    while (n < 280) begin
      if (n > 80 && n < 200) calm_phase = 1'b1;
      else calm_phase = 1'b0;
      case ($urandom_range(19))
        0: begin send_byte(word_char(26), 1'b1); n++; end
        1: begin send_byte($urandom_range(1) ? CHAR_SPACE : CHAR_NEWLINE, 1'b1); n++; end
        2: begin
          for (int k = 0; k < 33 + $urandom_range(5); k++) send_byte(word_char(2), 1'b0);
          send_byte(CHAR_SPACE, 1'b0);
          n += 35;
        end
        3: begin send_byte(8'($urandom_range(255)), 1'($urandom_range(1))); n++; end
        default: begin
          for (int k = 0; k <= $urandom_range(3); k++) begin
            send_byte(word_char(3), 1'b0);
            n++;
          end
          send_byte($urandom_range(1) ? CHAR_SPACE : CHAR_NEWLINE, 1'b0);
          n++;
        end
      endcase
    end
    send_byte(CHAR_SPACE, 1'b1);
    calm_phase = 1'b0;
    in_valid_i <= 1'b0;
    while (words_pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("covered %0d text bytes and %0d words: repeats, table full,", bytes_sent,
             words_seen);
    $display("overlong words, end of text and output hold-off");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: count cycles without any accepted transaction outside an output hold.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni
        || hold_output) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule
